// ===== hw/rtl/sapd_pkg.sv =====
// ----------------------------------------------------------------------------
// sapd_pkg
// Shared types, constants and the symbol decoder of the suffix array builder.
// ----------------------------------------------------------------------------
package sapd_pkg;

    localparam int MAX_LEN_DEF       = 1024;
    localparam int ALPHABET_SIZE_DEF = 5;

    // symbol codes
    localparam logic [4:0] CODE_END  = 5'd0;
    localparam logic [4:0] CODE_A    = 5'd1;
    localparam logic [4:0] CODE_C    = 5'd2;
    localparam logic [4:0] CODE_G    = 5'd3;
    localparam logic [4:0] CODE_T    = 5'd4;
    localparam logic [4:0] CODE_NONE = 5'h1F;

    // result status
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_SYM = 2'd1;
    localparam logic [1:0] ST_TOO_LONG = 2'd2;
    localparam logic [1:0] ST_NO_RANK = 2'd3;

    // input commands
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef logic [4:0] t_op;

    // controller states, each one an operation of the datapath
    localparam t_op OP_IDLE  = 5'd0;
    localparam t_op OP_RD    = 5'd1;
    localparam t_op OP_RD2   = 5'd2;
    localparam t_op OP_CLR   = 5'd3;
    localparam t_op OP_CNT_A = 5'd4;
    localparam t_op OP_CNT_B = 5'd5;
    localparam t_op OP_CNT_C = 5'd6;
    localparam t_op OP_PFX_A = 5'd7;
    localparam t_op OP_PFX_B = 5'd8;
    localparam t_op OP_DST_A = 5'd9;
    localparam t_op OP_DST_B = 5'd10;
    localparam t_op OP_DST_C = 5'd11;
    localparam t_op OP_DST_D = 5'd12;
    localparam t_op OP_CPO_A = 5'd13;
    localparam t_op OP_CPO_B = 5'd14;
    localparam t_op OP_CLS_A = 5'd15;
    localparam t_op OP_CLS_B = 5'd16;
    localparam t_op OP_CLS_C = 5'd17;
    localparam t_op OP_CLS_D = 5'd18;
    localparam t_op OP_CPC_A = 5'd19;
    localparam t_op OP_CPC_B = 5'd20;
    localparam t_op OP_DBL   = 5'd21;
    localparam t_op OP_CHK   = 5'd22;
    localparam t_op OP_FIN   = 5'd23;

    typedef struct packed {
        t_op  op;
        logic dbl;   // doubled round rather than first character pass
        logic inc;
        logic dec;
        logic zero;
        logic top;
    } t_cmd;

    typedef struct packed {
        logic start_build;
        logic start_read;
        logic idx_at_k;
        logic idx_at_n;
        logic idx_zero;
        logic step_done;
    } t_sts;

    function automatic logic [4:0] sym_code(input logic [7:0] s);
        logic [4:0] c;
        unique case (s)
            8'h24:   c = CODE_END;
            8'h41:   c = CODE_A;
            8'h43:   c = CODE_C;
            8'h47:   c = CODE_G;
            8'h54:   c = CODE_T;
            default: c = CODE_NONE;
        endcase
        return c;
    endfunction

endpackage

// ===== hw/rtl/suffix_array_prefix_doubling.sv =====
// ----------------------------------------------------------------------------
// suffix_array_prefix_doubling
// Suffix array of a DNA text by prefix doubling with counting sorts.
// ----------------------------------------------------------------------------
// channel | valid        | stall        | payload
// input   | i_in_valid   | o_in_stall   | i_cmd, i_symbol, i_last, i_rank
// output  | o_out_valid  | i_out_stall  | o_position, o_status
//
// A load or a failed read registers its result directly; a good read passes
// through OP_RD and OP_RD2 first. The last byte of a good text starts a
// build: a first pass by symbol, then ceil(log2(n)) doubling rounds; each
// memory allows one read and one write per cycle.
// Synchronous active-low reset empties the text; memories are not cleared.
// The input stalls during a build or read and while a result waits stalled.
// ----------------------------------------------------------------------------
module suffix_array_prefix_doubling #(
    parameter int MAX_LEN       = sapd_pkg::MAX_LEN_DEF,
    parameter int ALPHABET_SIZE = sapd_pkg::ALPHABET_SIZE_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic                       i_cmd,
    input  logic [7:0]                 i_symbol,
    input  logic                       i_last,
    input  logic [$clog2(MAX_LEN)-1:0] i_rank,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [$clog2(MAX_LEN)-1:0] o_position,
    output logic [1:0]                 o_status
);

    sapd_pkg::t_cmd w_cmd;
    sapd_pkg::t_sts w_sts;
    logic           w_busy;
    logic           w_accept;

    assign o_in_stall = w_busy || (o_out_valid && i_out_stall);
    assign w_accept   = i_in_valid && !o_in_stall;

    sapd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .o_busy  (w_busy)
    );

    sapd_dp #(
        .MAX_LEN       (MAX_LEN),
        .ALPHABET_SIZE (ALPHABET_SIZE)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_accept    (w_accept),
        .i_cmd_bit   (i_cmd),
        .i_symbol    (i_symbol),
        .i_last      (i_last),
        .i_rank      (i_rank),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_position  (o_position),
        .o_status    (o_status)
    );

`ifndef SYNTHESIS
    a_start_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_sts.start_build || w_sts.start_read) |=> w_busy)
        else $error("build or read did not start");

    a_no_start_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_busy |-> !(w_sts.start_build || w_sts.start_read))
        else $error("new work started while busy");

    a_read_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.op == sapd_pkg::OP_RD2) |=> (o_out_valid && o_status == sapd_pkg::ST_OK))
        else $error("rank read lost its result");
`endif

endmodule

// ===== hw/rtl/sapd_ram.sv =====
// ----------------------------------------------------------------------------
// sapd_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module sapd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/sapd_ctrl.sv =====
// ----------------------------------------------------------------------------
// sapd_ctrl
// Sequencer of the build: clear, count, prefix sum, distribute, classify (and
// copy back in doubling rounds), repeated per doubling round; also the rank read.
// ----------------------------------------------------------------------------
module sapd_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  sapd_pkg::t_sts  i_sts,
    output sapd_pkg::t_cmd  o_cmd,
    output logic            o_busy
);

    sapd_pkg::t_op r_state, n_state;
    logic          r_dbl, n_dbl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sapd_pkg::OP_IDLE;
            r_dbl   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_dbl   <= n_dbl;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_dbl      = r_dbl;
        o_cmd.op   = r_state;
        o_cmd.dbl  = r_dbl;
        o_cmd.inc  = 1'b0;
        o_cmd.dec  = 1'b0;
        o_cmd.zero = 1'b0;
        o_cmd.top  = 1'b0;
        unique case (r_state)
            sapd_pkg::OP_IDLE: begin
                if (i_sts.start_build) begin
                    n_dbl      = 1'b0;
                    o_cmd.zero = 1'b1;
                    n_state    = sapd_pkg::OP_CLR;
                end else if (i_sts.start_read) begin
                    n_state = sapd_pkg::OP_RD;
                end
            end
            sapd_pkg::OP_RD:  n_state = sapd_pkg::OP_RD2;
            sapd_pkg::OP_RD2: n_state = sapd_pkg::OP_IDLE;
            sapd_pkg::OP_CLR: begin
                if (i_sts.idx_at_k) begin
                    o_cmd.zero = 1'b1;
                    n_state    = sapd_pkg::OP_CNT_A;
                end else begin
                    o_cmd.inc = 1'b1;
                end
            end
            sapd_pkg::OP_CNT_A: n_state = sapd_pkg::OP_CNT_B;
            sapd_pkg::OP_CNT_B: n_state = sapd_pkg::OP_CNT_C;
            sapd_pkg::OP_CNT_C: begin
                if (i_sts.idx_at_n) begin
                    o_cmd.zero = 1'b1;
                    n_state    = sapd_pkg::OP_PFX_A;
                end else begin
                    o_cmd.inc = 1'b1;
                    n_state   = sapd_pkg::OP_CNT_A;
                end
            end
            sapd_pkg::OP_PFX_A: n_state = sapd_pkg::OP_PFX_B;
            sapd_pkg::OP_PFX_B: begin
                if (i_sts.idx_at_k) begin
                    o_cmd.top = 1'b1;
                    n_state   = sapd_pkg::OP_DST_A;
                end else begin
                    o_cmd.inc = 1'b1;
                    n_state   = sapd_pkg::OP_PFX_A;
                end
            end
            sapd_pkg::OP_DST_A: n_state = r_dbl ? sapd_pkg::OP_DST_B : sapd_pkg::OP_DST_C;
            sapd_pkg::OP_DST_B: n_state = sapd_pkg::OP_DST_C;
            sapd_pkg::OP_DST_C: n_state = sapd_pkg::OP_DST_D;
            sapd_pkg::OP_DST_D: begin
                if (i_sts.idx_zero) begin
                    o_cmd.zero = 1'b1;
                    n_state    = r_dbl ? sapd_pkg::OP_CPO_A : sapd_pkg::OP_CLS_A;
                end else begin
                    o_cmd.dec = 1'b1;
                    n_state   = sapd_pkg::OP_DST_A;
                end
            end
            sapd_pkg::OP_CPO_A: n_state = sapd_pkg::OP_CPO_B;
            sapd_pkg::OP_CPO_B: begin
                if (i_sts.idx_at_n) begin
                    o_cmd.zero = 1'b1;
                    n_state    = sapd_pkg::OP_CLS_A;
                end else begin
                    o_cmd.inc = 1'b1;
                    n_state   = sapd_pkg::OP_CPO_A;
                end
            end
            sapd_pkg::OP_CLS_A: n_state = sapd_pkg::OP_CLS_B;
            sapd_pkg::OP_CLS_B: n_state = r_dbl ? sapd_pkg::OP_CLS_C : sapd_pkg::OP_CLS_D;
            sapd_pkg::OP_CLS_C: n_state = sapd_pkg::OP_CLS_D;
            sapd_pkg::OP_CLS_D: begin
                if (i_sts.idx_at_n) begin
                    o_cmd.zero = 1'b1;
                    n_state    = r_dbl ? sapd_pkg::OP_CPC_A : sapd_pkg::OP_CHK;
                end else begin
                    o_cmd.inc = 1'b1;
                    n_state   = sapd_pkg::OP_CLS_A;
                end
            end
            sapd_pkg::OP_CPC_A: n_state = sapd_pkg::OP_CPC_B;
            sapd_pkg::OP_CPC_B: begin
                if (i_sts.idx_at_n) begin
                    o_cmd.zero = 1'b1;
                    n_state    = sapd_pkg::OP_DBL;
                end else begin
                    o_cmd.inc = 1'b1;
                    n_state   = sapd_pkg::OP_CPC_A;
                end
            end
            sapd_pkg::OP_DBL: n_state = sapd_pkg::OP_CHK;
            sapd_pkg::OP_CHK: begin
                if (i_sts.step_done) begin
                    n_state = sapd_pkg::OP_FIN;
                end else begin
                    n_dbl      = 1'b1;
                    o_cmd.zero = 1'b1;
                    n_state    = sapd_pkg::OP_CLR;
                end
            end
            sapd_pkg::OP_FIN: n_state = sapd_pkg::OP_IDLE;
            default:          n_state = sapd_pkg::OP_IDLE;
        endcase
    end

    assign o_busy = (r_state != sapd_pkg::OP_IDLE);

endmodule

// ===== hw/rtl/sapd_dp.sv =====
// ----------------------------------------------------------------------------
// sapd_dp
// Datapath: text loader, the six memories, index and length registers,
// counting-sort arithmetic and the result register.
// ----------------------------------------------------------------------------
module sapd_dp #(
    parameter int MAX_LEN       = sapd_pkg::MAX_LEN_DEF,
    parameter int ALPHABET_SIZE = sapd_pkg::ALPHABET_SIZE_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  sapd_pkg::t_cmd             i_cmd,
    output sapd_pkg::t_sts             o_sts,
    input  logic                       i_accept,
    input  logic                       i_cmd_bit,
    input  logic [7:0]                 i_symbol,
    input  logic                       i_last,
    input  logic [$clog2(MAX_LEN)-1:0] i_rank,
    input  logic                       i_out_stall,
    output logic                       o_out_valid,
    output logic [$clog2(MAX_LEN)-1:0] o_position,
    output logic [1:0]                 o_status
);

    localparam int AW     = $clog2(MAX_LEN);
    localparam int NW     = $clog2(MAX_LEN + 1);
    localparam int SW     = NW + 1;
    localparam int TW     = $clog2(ALPHABET_SIZE);
    localparam int BDEPTH = (MAX_LEN > ALPHABET_SIZE) ? MAX_LEN : ALPHABET_SIZE;
    localparam int BW     = $clog2(BDEPTH);
    localparam int KW     = $clog2(BDEPTH + 1);
    localparam int VW     = (AW > TW) ? AW : TW;

    // loader and build state
    logic [NW-1:0] r_len, n_len;
    logic [1:0]    r_err, n_err;
    logic          r_built;
    logic [KW-1:0] r_k;
    logic [SW-1:0] r_step;
    logic [BW-1:0] r_idx;
    logic [AW-1:0] r_rank;
    // per-element work registers
    logic [BW-1:0] r_key;
    logic [AW-1:0] r_pos;
    logic [AW-1:0] r_cur;
    logic [AW-1:0] r_mid;
    logic [AW-1:0] r_ca;
    logic [AW-1:0] r_cls;
    logic [VW-1:0] r_p1;
    logic [AW-1:0] r_p2;
    logic [NW-1:0] r_acc;
    // result register
    logic          r_ovalid;
    logic [AW-1:0] r_opos;
    logic [1:0]    r_ostat;

    // memory ports
    logic          txt_we;
    logic [AW-1:0] txt_wa, txt_ra;
    logic [TW-1:0] txt_wd, txt_rd;
    logic          rnk_we;
    logic [AW-1:0] rnk_wa, rnk_ra, rnk_wd, rnk_rd;
    logic          cls_we;
    logic [AW-1:0] cls_wa, cls_ra, cls_wd, cls_rd;
    logic          nor_we;
    logic [AW-1:0] nor_wa, nor_ra, nor_wd, nor_rd;
    logic          ncl_we;
    logic [AW-1:0] ncl_wa, ncl_ra, ncl_wd, ncl_rd;
    logic          bkt_we;
    logic [BW-1:0] bkt_wa, bkt_ra;
    logic [NW-1:0] bkt_wd, bkt_rd;

    sapd_ram #(.WIDTH(TW), .DEPTH(MAX_LEN)) u_text (
        .i_clk(i_clk), .i_we(txt_we), .i_waddr(txt_wa), .i_wdata(txt_wd),
        .i_raddr(txt_ra), .o_rdata(txt_rd)
    );
    sapd_ram #(.WIDTH(AW), .DEPTH(MAX_LEN)) u_rank (
        .i_clk(i_clk), .i_we(rnk_we), .i_waddr(rnk_wa), .i_wdata(rnk_wd),
        .i_raddr(rnk_ra), .o_rdata(rnk_rd)
    );
    sapd_ram #(.WIDTH(AW), .DEPTH(MAX_LEN)) u_class (
        .i_clk(i_clk), .i_we(cls_we), .i_waddr(cls_wa), .i_wdata(cls_wd),
        .i_raddr(cls_ra), .o_rdata(cls_rd)
    );
    sapd_ram #(.WIDTH(AW), .DEPTH(MAX_LEN)) u_next_order (
        .i_clk(i_clk), .i_we(nor_we), .i_waddr(nor_wa), .i_wdata(nor_wd),
        .i_raddr(nor_ra), .o_rdata(nor_rd)
    );
    sapd_ram #(.WIDTH(AW), .DEPTH(MAX_LEN)) u_next_class (
        .i_clk(i_clk), .i_we(ncl_we), .i_waddr(ncl_wa), .i_wdata(ncl_wd),
        .i_raddr(ncl_ra), .o_rdata(ncl_rd)
    );
    sapd_ram #(.WIDTH(NW), .DEPTH(BDEPTH)) u_bucket (
        .i_clk(i_clk), .i_we(bkt_we), .i_waddr(bkt_wa), .i_wdata(bkt_wd),
        .i_raddr(bkt_ra), .o_rdata(bkt_rd)
    );

    // ---------------- loader ----------------
    logic [4:0]    code;
    logic          code_ok;
    logic [NW-1:0] len_eff;
    logic [1:0]    err_eff;
    logic          is_load, is_read;

    assign code    = sapd_pkg::sym_code(i_symbol);
    assign code_ok = (code != sapd_pkg::CODE_NONE) && (32'(code) < ALPHABET_SIZE);
    assign len_eff = r_built ? '0 : r_len;
    assign err_eff = r_built ? sapd_pkg::ST_OK : r_err;
    assign is_load = i_accept && (i_cmd_bit == sapd_pkg::CMD_LOAD);
    assign is_read = i_accept && (i_cmd_bit == sapd_pkg::CMD_READ);

    always_comb begin
        n_len = len_eff;
        n_err = err_eff;
        if (!code_ok) begin
            if (err_eff == sapd_pkg::ST_OK) begin
                n_err = sapd_pkg::ST_BAD_SYM;
            end
        end else if (32'(len_eff) >= MAX_LEN) begin
            if (err_eff == sapd_pkg::ST_OK) begin
                n_err = sapd_pkg::ST_TOO_LONG;
            end
        end else begin
            n_len = len_eff + NW'(1);
        end
    end

    logic store_sym;
    assign store_sym = is_load && code_ok && (32'(len_eff) < MAX_LEN);

    assign o_sts.start_build = is_load && i_last && (n_err == sapd_pkg::ST_OK) &&
                               (n_len != '0);
    assign o_sts.start_read  = is_read && r_built && (NW'(i_rank) < r_len);

    // ---------------- build arithmetic ----------------
    logic          op_is_dst_c, op_is_cnt_b;
    logic [BW-1:0] key_w;
    logic [NW-1:0] bkt_dec;
    logic [SW-1:0] start_sum, mid_sum;
    logic [AW-1:0] start_w, mid_w;
    logic [VW-1:0] v1;
    logic [AW-1:0] v2;
    logic          differ;
    logic [AW-1:0] new_cls;

    assign op_is_cnt_b = (i_cmd.op == sapd_pkg::OP_CNT_B);
    assign op_is_dst_c = (i_cmd.op == sapd_pkg::OP_DST_C);
    assign key_w   = i_cmd.dbl ? BW'(cls_rd) : BW'(txt_rd);
    assign bkt_dec = bkt_rd - NW'(1);

    // wrap by the shift: start = (pos - len) mod n, mid = (pos + len) mod n
    always_comb begin
        if (SW'(rnk_rd) >= r_step) begin
            start_sum = SW'(rnk_rd) - r_step;
        end else begin
            start_sum = SW'(rnk_rd) + SW'(r_len) - r_step;
        end
        mid_sum = SW'(rnk_rd) + r_step;
        if (mid_sum >= SW'(r_len)) begin
            mid_sum = mid_sum - SW'(r_len);
        end
    end
    assign start_w = start_sum[AW-1:0];
    assign mid_w   = mid_sum[AW-1:0];

    assign v1      = i_cmd.dbl ? VW'(r_ca) : VW'(txt_rd);
    assign v2      = i_cmd.dbl ? cls_rd : '0;
    assign differ  = (v1 != r_p1) || (v2 != r_p2);
    assign new_cls = (r_idx == '0) ? '0 : (r_cls + AW'(differ));

    // ---------------- memory port selection ----------------
    always_comb begin
        txt_we = store_sym;
        txt_wa = len_eff[AW-1:0];
        txt_wd = TW'(code);
        txt_ra = r_idx[AW-1:0];
        rnk_we = 1'b0;
        rnk_wa = r_idx[AW-1:0];
        rnk_wd = nor_rd;
        rnk_ra = r_idx[AW-1:0];
        cls_we = 1'b0;
        cls_wa = r_idx[AW-1:0];
        cls_wd = ncl_rd;
        cls_ra = r_idx[AW-1:0];
        nor_we = 1'b0;
        nor_wa = bkt_dec[AW-1:0];
        nor_wd = r_pos;
        nor_ra = r_idx[AW-1:0];
        ncl_we = 1'b0;
        ncl_wa = r_cur;
        ncl_wd = new_cls;
        ncl_ra = r_idx[AW-1:0];
        bkt_we = 1'b0;
        bkt_wa = r_idx;
        bkt_wd = '0;
        bkt_ra = r_idx;
        unique case (i_cmd.op)
            sapd_pkg::OP_RD: rnk_ra = r_rank;
            sapd_pkg::OP_CLR: bkt_we = 1'b1;
            sapd_pkg::OP_CNT_B: bkt_ra = key_w;
            sapd_pkg::OP_CNT_C: begin
                bkt_we = 1'b1;
                bkt_wa = r_key;
                bkt_wd = bkt_rd + NW'(1);
            end
            sapd_pkg::OP_PFX_B: begin
                bkt_we = 1'b1;
                bkt_wd = r_acc + bkt_rd;
            end
            sapd_pkg::OP_DST_B: cls_ra = start_w;
            sapd_pkg::OP_DST_C: bkt_ra = key_w;
            sapd_pkg::OP_DST_D: begin
                bkt_we = 1'b1;
                bkt_wa = r_key;
                bkt_wd = bkt_dec;
                if (i_cmd.dbl) begin
                    nor_we = 1'b1;
                end else begin
                    rnk_we = 1'b1;
                    rnk_wa = bkt_dec[AW-1:0];
                    rnk_wd = r_pos;
                end
            end
            sapd_pkg::OP_CPO_B: rnk_we = 1'b1;
            sapd_pkg::OP_CLS_B: begin
                txt_ra = rnk_rd;
                cls_ra = rnk_rd;
            end
            sapd_pkg::OP_CLS_C: cls_ra = r_mid;
            sapd_pkg::OP_CLS_D: begin
                if (i_cmd.dbl) begin
                    ncl_we = 1'b1;
                end else begin
                    cls_we = 1'b1;
                    cls_wa = r_cur;
                    cls_wd = new_cls;
                end
            end
            sapd_pkg::OP_CPC_B: cls_we = 1'b1;
            default: ;
        endcase
    end

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len    <= '0;
            r_err    <= sapd_pkg::ST_OK;
            r_built  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && !i_out_stall) begin
                r_ovalid <= 1'b0;
            end
            if (is_load) begin
                r_built <= 1'b0;
                if (i_last && !o_sts.start_build) begin
                    // failed text: back to empty
                    r_len <= '0;
                    r_err <= sapd_pkg::ST_OK;
                end else begin
                    r_len <= n_len;
                    r_err <= n_err;
                end
                if (i_last) begin
                    r_ovalid <= 1'b1;
                end
            end
            if (is_read && !o_sts.start_read) begin
                r_ovalid <= 1'b1;
            end
            if (i_cmd.op == sapd_pkg::OP_RD2) begin
                r_ovalid <= 1'b1;
            end
            if (i_cmd.op == sapd_pkg::OP_FIN) begin
                r_built <= 1'b1;
            end
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge i_clk) begin
        if (is_load && i_last) begin
            r_opos  <= '0;
            r_ostat <= n_err;
        end else if (is_read) begin
            r_opos  <= '0;
            r_ostat <= sapd_pkg::ST_NO_RANK;
            r_rank  <= i_rank;
        end else if (i_cmd.op == sapd_pkg::OP_RD2) begin
            r_opos  <= rnk_rd;
            r_ostat <= sapd_pkg::ST_OK;
        end
        if (o_sts.start_build) begin
            r_step <= SW'(1);
            r_k    <= (32'(n_len) > ALPHABET_SIZE) ? KW'(n_len) : KW'(ALPHABET_SIZE);
        end else if (i_cmd.op == sapd_pkg::OP_DBL) begin
            r_step <= r_step << 1;
        end
        if (i_cmd.zero) begin
            r_idx <= '0;
            r_acc <= '0;
        end else if (i_cmd.top) begin
            r_idx <= BW'(r_len - NW'(1));
        end else if (i_cmd.inc) begin
            r_idx <= r_idx + BW'(1);
        end else if (i_cmd.dec) begin
            r_idx <= r_idx - BW'(1);
        end
        if (op_is_cnt_b || op_is_dst_c) begin
            r_key <= key_w;
        end
        if (op_is_dst_c && !i_cmd.dbl) begin
            r_pos <= r_idx[AW-1:0];
        end
        if (i_cmd.op == sapd_pkg::OP_DST_B) begin
            r_pos <= start_w;
        end
        if (i_cmd.op == sapd_pkg::OP_PFX_B) begin
            r_acc <= r_acc + bkt_rd;
        end
        if (i_cmd.op == sapd_pkg::OP_CLS_B) begin
            r_cur <= rnk_rd;
            r_mid <= mid_w;
        end
        if (i_cmd.op == sapd_pkg::OP_CLS_C) begin
            r_ca <= cls_rd;
        end
        if (i_cmd.op == sapd_pkg::OP_CLS_D) begin
            r_cls <= new_cls;
            r_p1  <= v1;
            r_p2  <= v2;
        end
    end

    // ---------------- status ----------------
    assign o_sts.idx_at_k  = (KW'(r_idx) == (r_k - KW'(1)));
    assign o_sts.idx_at_n  = (KW'(r_idx) == (KW'(r_len) - KW'(1)));
    assign o_sts.idx_zero  = (r_idx == '0);
    assign o_sts.step_done = (r_step >= SW'(r_len));

    assign o_out_valid = r_ovalid;
    assign o_position  = r_opos;
    assign o_status    = r_ostat;

endmodule

// ===== tb/tb_suffix_array_prefix_doubling.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_suffix_array_prefix_doubling
// Loads DNA texts (directed and random), lets the block build each suffix
// array, reads ranks back and compares every result word with a predictor
// that rebuilds the same array by prefix doubling with stable counting sorts.
// ----------------------------------------------------------------------------

class suffix_rank_board;
    localparam int TXT_MAX = sapd_pkg::MAX_LEN_DEF;

    logic [2:0] text_sym [TXT_MAX];
    logic [9:0] order [TXT_MAX];
    logic [9:0] order_nx [TXT_MAX];
    logic [9:0] klass [TXT_MAX];
    logic [9:0] klass_nx [TXT_MAX];
    int         bucket [TXT_MAX + 16];
    int         length;
    bit         ready;
    logic [1:0] load_err;

    logic [9:0] want_pos [$];
    logic [1:0] want_status [$];
    int         mismatches;
    int         checked;
    int         builds;

    function new();
        length = 0;
        ready = 0;
        load_err = sapd_pkg::ST_OK;
        mismatches = 0;
        checked = 0;
        builds = 0;
    endfunction

    function logic [4:0] decode(logic [7:0] s);
        case (s)
            "$": return sapd_pkg::CODE_END;
            "A": return sapd_pkg::CODE_A;
            "C": return sapd_pkg::CODE_C;
            "G": return sapd_pkg::CODE_G;
            "T": return sapd_pkg::CODE_T;
            default: return sapd_pkg::CODE_NONE;
        endcase
    endfunction

    // append one expected result word
    function void queue_word(logic [9:0] pos, logic [1:0] status);
        want_pos.insert(want_pos.size(), pos);
        want_status.insert(want_status.size(), status);
    endfunction

    function void clear_buckets();
        foreach (bucket[i]) bucket[i] = 0;
    endfunction

    function void rebuild(int n);
        int len;
        int c;
        int st;
        int cur;
        int prv;
        bit differ;
        len = 1;
        clear_buckets();
        for (int i = 0; i < n; i++) bucket[text_sym[i]]++;
        for (c = 1; c < sapd_pkg::ALPHABET_SIZE_DEF; c++) bucket[c] += bucket[c - 1];
        for (int i = n - 1; i >= 0; i--) begin
            c = text_sym[i];
            bucket[c]--;
            order[bucket[c]] = i;
        end
        klass[order[0]] = 0;
        for (int i = 1; i < n; i++) begin
            cur = order[i];
            prv = order[i - 1];
            klass[cur] = klass[prv] + (text_sym[cur] != text_sym[prv]);
        end
        while (len < n) begin
            // sort by the class of the rotation len places earlier
            clear_buckets();
            for (int i = 0; i < n; i++) bucket[klass[i]]++;
            for (int i = 1; i < n; i++) bucket[i] += bucket[i - 1];
            for (int i = n - 1; i >= 0; i--) begin
                st = (order[i] + n - len) % n;
                c = klass[st];
                bucket[c]--;
                order_nx[bucket[c]] = st;
            end
            for (int i = 0; i < n; i++) order[i] = order_nx[i];
            klass_nx[order[0]] = 0;
            for (int i = 1; i < n; i++) begin
                cur = order[i];
                prv = order[i - 1];
                differ = klass[cur] != klass[prv] ||
                         klass[(cur + len) % n] != klass[(prv + len) % n];
                klass_nx[cur] = klass_nx[prv] + differ;
            end
            for (int i = 0; i < n; i++) klass[i] = klass_nx[i];
            len *= 2;
        end
    endfunction

    function void note_word(logic cmd, logic [7:0] sym, logic last, logic [9:0] rank);
        logic [4:0] code;
        if (cmd == sapd_pkg::CMD_READ) begin
            if (ready && rank < length)
                queue_word(order[rank], sapd_pkg::ST_OK);
            else
                queue_word('0, sapd_pkg::ST_NO_RANK);
            return;
        end
        if (ready) begin
            ready = 0;
            length = 0;
            load_err = sapd_pkg::ST_OK;
        end
        code = decode(sym);
        if (code == sapd_pkg::CODE_NONE) begin
            if (load_err == sapd_pkg::ST_OK) load_err = sapd_pkg::ST_BAD_SYM;
        end else if (length >= TXT_MAX) begin
            if (load_err == sapd_pkg::ST_OK) load_err = sapd_pkg::ST_TOO_LONG;
        end else begin
            text_sym[length] = code[2:0];
            length++;
        end
        if (!last) return;
        queue_word('0, load_err);
        if (load_err == sapd_pkg::ST_OK && length > 0) begin
            rebuild(length);
            ready = 1;
            builds++;
        end else begin
            length = 0;
            load_err = sapd_pkg::ST_OK;
        end
    endfunction

    function void check_word(logic [9:0] pos, logic [1:0] status);
        logic [9:0] ep;
        logic [1:0] es;
        checked++;
        if (want_pos.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected word: position %0d status %0d", pos, status);
            return;
        end
        ep = want_pos.pop_front();
        es = want_status.pop_front();
        if (pos !== ep || status !== es) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: expected position %0d status %0d, got %0d status %0d",
                         ep, es, pos, status);
        end
    endfunction

    function int pending();
        return want_pos.size();
    endfunction
endclass

module tb_suffix_array_prefix_doubling;
    localparam int WATCHDOG_LIMIT = 800000;
    localparam int LONG_HOLD      = 400;
    localparam int LONG_TEXT      = 200;
    localparam int WORD_TARGET    = 700;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    logic       i_cmd;
    logic [7:0] i_symbol;
    logic       i_last;
    logic [9:0] i_rank;
    logic       o_out_valid;
    logic       i_out_stall;
    logic [9:0] o_position;
    logic [1:0] o_status;

    suffix_rank_board board;
    bit quiet;
    bit hold_req;
    int idle_cycles;
    int words_sent;

    suffix_array_prefix_doubling dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_cmd       (i_cmd),
        .i_symbol    (i_symbol),
        .i_last      (i_last),
        .i_rank      (i_rank),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_position  (o_position),
        .o_status    (o_status)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function int draw_gap();
        return quiet ? 0 : $urandom_range(0, 8);
    endfunction

    task automatic send_word(logic cmd, logic [7:0] sym, logic last, logic [9:0] rank);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cmd      <= cmd;
        i_symbol   <= sym;
        i_last     <= last;
        i_rank     <= rank;
        do @(posedge i_clk); while (o_in_stall);
        board.note_word(cmd, sym, last, rank);
        words_sent++;
    endtask

    task automatic load_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_word(sapd_pkg::CMD_LOAD, s[i], i == s.len() - 1, $urandom_range(0, 1023));
    endtask

    task automatic read_rank(logic [9:0] rank);
        send_word(sapd_pkg::CMD_READ, $urandom_range(0, 255), $urandom_range(0, 1), rank);
    endtask

    function logic [7:0] dna_char();
        case ($urandom_range(0, 4))
            0: return "$";
            1: return "A";
            2: return "C";
            3: return "G";
            default: return "T";
        endcase
    endfunction

    // result side
    initial begin
        int gap;
        wait (i_rst_n === 1'b1);
        forever begin
            if (hold_req) begin
                hold_req = 0;
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else begin
                gap = draw_gap();
                if (gap > 0) begin
                    i_out_stall <= 1'b1;
                    repeat (gap) @(posedge i_clk);
                end
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
            board.check_word(o_position, o_status);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no progress, %0d words still expected", board.pending());
            $display("tb_suffix_array_prefix_doubling failed");
            $finish;
        end
    end

    initial begin
        int n;
        int reads;
        string s;
        board = new();
        quiet = 0;
        hold_req = 0;
        idle_cycles = 0;
        words_sent = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_cmd = sapd_pkg::CMD_LOAD;
        i_symbol = '0;
        i_last = 1'b0;
        i_rank = '0;
        i_out_stall = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: read before any build, single byte text, periodic texts
        read_rank(0);
        load_text("$");
        read_rank(0);
        read_rank(1);
        load_text("ACAC");
        for (int r = 0; r < 5; r++) read_rank(10'(r));
        load_text("AAAA$");
        read_rank(4);
        read_rank(5);
        // bad symbol mid-text, then bad symbol as the final byte
        load_text("GAxT");
        read_rank(0);
        load_text("TTC?");
        load_text("GATTACA$");
        read_rank(7);
        read_rank(1023);

        // long text: many doubling rounds back to back
        quiet = 1;
        s = "";
        for (int i = 0; i < LONG_TEXT; i++) s = {s, string'(dna_char())};
        load_text(s);
        read_rank(0);
        read_rank(10'(LONG_TEXT - 1));
        read_rank(10'(LONG_TEXT));
        quiet = 0;

        // random: mostly well-formed texts with reads, some noise
        for (int k = 0; words_sent < WORD_TARGET; k++) begin
            if (k % 15 == 0) quiet = !quiet && ($urandom_range(0, 2) == 0);
            if (k == 12) hold_req = 1;
            if ($urandom_range(0, 9) < 8) begin
                n = $urandom_range(1, 24);
                for (int i = 0; i < n; i++)
                    send_word(sapd_pkg::CMD_LOAD,
                              ($urandom_range(0, 19) == 0) ? 8'($urandom) : dna_char(),
                              i == n - 1, $urandom_range(0, 1023));
                reads = $urandom_range(1, 6);
                for (int i = 0; i < reads; i++)
                    read_rank(($urandom_range(0, 7) == 0) ? $urandom_range(0, 1023)
                                                          : $urandom_range(0, n + 1));
            end else begin
                send_word($urandom_range(0, 1), $urandom_range(0, 255),
                          $urandom_range(0, 1), $urandom_range(0, 1023));
            end
        end
        i_in_valid <= 1'b0;

        while (board.pending() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        $display("run covered %0d input words, %0d result words, %0d suffix arrays built",
                 words_sent, board.checked, board.builds);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("tb_suffix_array_prefix_doubling passed");
        else begin
            $display("%0d mismatches", board.mismatches);
            $display("tb_suffix_array_prefix_doubling failed");
        end
        $finish;
    end
endmodule
